// ===== hw/rtl/variable_width_bit_packer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// variable_width_bit_packer_unit_assert.svh
// Assertion macros for the bit packer; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_BIT_PACKER_UNIT_ASSERT_SVH
`define VARIABLE_WIDTH_BIT_PACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VWBP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define VWBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VWBP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define VWBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/vwbp_pkg.sv =====
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared constants and types of the variable-width bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package vwbp_pkg;

    localparam int WORD_BITS    = 64;
    localparam int VALUE_BITS   = 64;
    localparam int WIDTH_BITS   = 7;
    localparam int FILL_BITS    = $clog2(WORD_BITS + 1);
    localparam int S_TDATA_BITS = ((VALUE_BITS + WIDTH_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 64;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    // op codes on s_tuser
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // item kinds in the queue
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [WORD_BITS-1:0]  value;
        logic [FILL_BITS-1:0]  width;
    } item_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [QCNT_BITS-1:0]  count;
    } queue_status_t;

    typedef struct packed {
        logic                  pop;
        logic                  pop_flush;
        logic [FILL_BITS-1:0]  fill;
    } back_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vwbp_front.sv =====
// ----------------------------------------------------------------------------
// vwbp_front
// Classify incoming items: clamp and mask appends, drop zero-width appends.
// ----------------------------------------------------------------------------
`default_nettype none

module vwbp_front
    import vwbp_pkg::*;
(
    input  wire logic                     s_tvalid,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,
    input  wire logic [0:0]               s_tuser,
    output item_t                         push_item,
    output logic                          push
);

    logic [WIDTH_BITS-1:0] raw_width;
    logic [VALUE_BITS-1:0] raw_value;
    logic [FILL_BITS-1:0]  clamped_width;
    logic [VALUE_BITS-1:0] value_mask;
    logic                  is_flush;

    always_comb begin
        raw_value = s_tdata[VALUE_BITS-1:0];
        raw_width = s_tdata[VALUE_BITS +: WIDTH_BITS];
        is_flush  = (s_tuser[0] == OP_FLUSH);

        // clamp oversized widths to a full word
        if (raw_width > WIDTH_BITS'(WORD_BITS)) begin
            clamped_width = FILL_BITS'(WORD_BITS);
        end else begin
            clamped_width = FILL_BITS'(raw_width);
        end

        if (32'(clamped_width) >= VALUE_BITS) begin
            value_mask = '1;
        end else begin
            value_mask = (VALUE_BITS'(1) << clamped_width) - VALUE_BITS'(1);
        end

        push_item.kind  = is_flush ? KIND_FLUSH : KIND_APPEND;
        push_item.value = WORD_BITS'(raw_value & value_mask);
        push_item.width = clamped_width;

        // zero-width appends change nothing: drop them here
        push = s_tvalid && (is_flush || (clamped_width != '0));
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vwbp_queue.sv =====
// ----------------------------------------------------------------------------
// vwbp_queue
// Short FIFO between front and back; push and pop may share a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vwbp_queue
    import vwbp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire item_t   push_item,
    input  wire logic    pop,
    output item_t        head_item,
    output queue_status_t status
);

    item_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    always_comb begin
        status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        status.count = count_reg;
        do_push = push && !status.full;
        do_pop  = pop && !status.empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end

        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end

        head_item = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vwbp_back.sv =====
// ----------------------------------------------------------------------------
// vwbp_back
// Merge fields into the pending word and emit finished words and, on flush, the partial word.
// ----------------------------------------------------------------------------
`default_nettype none

module vwbp_back
    import vwbp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire item_t                    head_item,
    input  wire logic                     head_valid,
    output logic                          pop,
    output back_status_t                  status,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,
    output logic [0:0]                    m_tuser
);

    logic [WORD_BITS-1:0]  pending_reg, pending_next;
    logic [FILL_BITS-1:0]  fill_reg, fill_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]  out_word_reg;
    logic                  out_flush_reg;

    logic [FILL_BITS:0]    sum;
    logic [FILL_BITS-1:0]  room;
    logic [WORD_BITS-1:0]  merged;
    logic [WORD_BITS-1:0]  carry;
    logic                  fits;
    logic                  emit;
    logic [WORD_BITS-1:0]  emit_word;
    logic                  emit_flush;

    always_comb begin
        pop = head_valid && (!out_valid_reg || m_tready);

        sum    = {1'b0, fill_reg} + {1'b0, head_item.width};
        room   = FILL_BITS'(WORD_BITS) - fill_reg;
        merged = pending_reg | (head_item.value << fill_reg);
        carry  = head_item.value >> room;
        fits   = (sum <= (FILL_BITS + 1)'(WORD_BITS));

        pending_next = pending_reg;
        fill_next    = fill_reg;
        emit         = 1'b0;
        emit_word    = merged;
        emit_flush   = 1'b0;

        if (pop) begin
            unique case (head_item.kind)
                KIND_APPEND: begin
                    if (fits) begin
                        pending_next = merged;
                        fill_next    = sum[FILL_BITS-1:0];
                    end else begin
                        emit         = 1'b1;
                        pending_next = carry;
                        fill_next    = FILL_BITS'(sum - (FILL_BITS + 1)'(WORD_BITS));
                    end
                end
                KIND_FLUSH: begin
                    emit         = (fill_reg != '0);
                    emit_word    = pending_reg;
                    emit_flush   = 1'b1;
                    pending_next = '0;
                    fill_next    = '0;
                end
                default: begin
                    pending_next = pending_reg;
                end
            endcase
        end

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        status.pop       = pop;
        status.pop_flush = pop && (head_item.kind == KIND_FLUSH);
        status.fill      = fill_reg;

        m_tvalid   = out_valid_reg;
        m_tdata    = M_TDATA_BITS'(out_word_reg);
        m_tuser[0] = out_flush_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pending_reg   <= pending_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_word_reg  <= emit_word;
            out_flush_reg <= emit_flush;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/variable_width_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// variable_width_bit_packer_unit: LSB-first packer of 1..64-bit fields
// Path: an item is registered in the queue, then its finished word in the output register.
// Throughput: one item per cycle while the output is not stalled, set by the single shift-and-OR in the back.
// Reset: synchronous active-low aresetn; empties queue and pending word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "variable_width_bit_packer_unit_assert.svh"

module variable_width_bit_packer_unit
    import vwbp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // field_value, field_width, zero pad
    input  wire logic [0:0]               s_tuser,   // op
    // result stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_BITS-1:0]       m_tdata,   // packed_word
    output logic [0:0]                    m_tuser    // from_flush
);

    // Front: clamp width, mask value, drop zero-width appends.
    item_t         q_push_item;
    logic          q_push;
    // Queue between front and back so each side stalls on its own.
    item_t         q_head_item;
    queue_status_t q_status;
    // Back: merge into pending word, emit into output register.
    logic          q_pop;
    back_status_t  b_status;

    // Push only on an accepted word.
    vwbp_front u_front (
        .s_tvalid  (s_tvalid && s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push_item (q_push_item),
        .push      (q_push)
    );

    vwbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head_item (q_head_item),
        .status    (q_status)
    );

    vwbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_item  (q_head_item),
        .head_valid (!q_status.empty),
        .pop        (q_pop),
        .status     (b_status),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Accept whenever the queue has room, dropped items included.
    assign s_tready = !q_status.full;

    // Never push into a full queue.
    `VWBP_ASSERT_NOW(a_queue_no_overflow, aclk, aresetn, q_status.full, !q_push, "queue overflow")
    // An empty queue must take input.
    `VWBP_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, q_status.count == '0, s_tready, "not ready while empty")
    // Flush leaves the packer empty.
    `VWBP_ASSERT_NEXT(a_flush_clears, aclk, aresetn, b_status.pop_flush, b_status.fill == '0, "flush did not clear fill")
    // Fill count never passes the word size.
    `VWBP_ASSERT_NEXT(a_fill_in_range, aclk, aresetn, b_status.pop, b_status.fill <= FILL_BITS'(WORD_BITS), "fill count out of range")

endmodule

`default_nettype wire

// ===== tb/tb_variable_width_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_variable_width_bit_packer_unit
// Self-checking bench for the LSB-first bit packer. A scoreboard class packs
// every accepted field into its own copy of the pending word and queues the
// words it expects. Each word leaving the block is compared against the oldest
// one. Directed corner items run first, then random fields with idle gaps on
// both sides, a long receiver hold-off and a full drain in the middle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_variable_width_bit_packer_unit;
    import vwbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int RX_HOLD_CYCLES = 250;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;     // margin for words still in the pipe
    localparam int IDLE_LIMIT     = 3000;  // cycles without any word moving
    localparam int MAX_REPORTS    = 20;

    // ------------------------------------------------------------------------
    // Scoreboard: bit-accurate packer plus the queue of words still owed
    // ------------------------------------------------------------------------
    class packer_scoreboard;
        logic [WORD_BITS-1:0] pending_bits;
        int unsigned          bits_held;
        logic [WORD_BITS-1:0] owed_words[$];
        bit                   owed_flush_flags[$];
        int unsigned          mismatches;
        int unsigned          words_checked;
        int unsigned          flush_words_seen;

        function new();
            pending_bits     = '0;
            bits_held        = 0;
            mismatches       = 0;
            words_checked    = 0;
            flush_words_seen = 0;
        endfunction

        function int unsigned words_owed();
            return owed_words.size();
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Append one owed word and its flush flag at the tail.
        function void owe_word(input logic [WORD_BITS-1:0] word, input bit flag);
            owed_words.insert(owed_words.size(), word);
            owed_flush_flags.insert(owed_flush_flags.size(), flag);
        endfunction

        // Pack one accepted input word and queue the result it causes, if any.
        function void absorb_field(input logic op, input logic [63:0] value,
                                   input logic [6:0] width);
            int unsigned            w;
            logic [WORD_BITS-1:0]   field_mask;
            logic [2*WORD_BITS-1:0] merged;

            if (op == OP_FLUSH) begin
                // emit a partial word only when bits are held, then clear
                if (bits_held > 0)
                    owe_word(pending_bits, 1'b1);
                pending_bits = '0;
                bits_held    = 0;
                return;
            end

            w = width;
            if (w == 0)
                return;
            if (w > WORD_BITS)
                w = WORD_BITS;
            field_mask = (w >= WORD_BITS) ? '1 : ((64'd1 << w) - 64'd1);

            // place the field above the held bits in a double-width window
            merged = {{WORD_BITS{1'b0}}, pending_bits}
                   | ({{WORD_BITS{1'b0}}, value & field_mask} << bits_held);

            if (bits_held + w <= WORD_BITS) begin
                pending_bits = merged[WORD_BITS-1:0];
                bits_held    = bits_held + w;
            end else begin
                owe_word(merged[WORD_BITS-1:0], 1'b0);
                pending_bits = merged[2*WORD_BITS-1:WORD_BITS];
                bits_held    = bits_held + w - WORD_BITS;
            end
        endfunction

        // Compare one word leaving the block with the oldest owed word.
        task check_word(input logic [M_TDATA_BITS-1:0] word, input logic flush_flag);
            logic [WORD_BITS-1:0] want_word;
            bit                   want_flag;

            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h (flush %0b)",
                                          word, flush_flag));
                return;
            end
            want_word = owed_words.pop_front();
            want_flag = owed_flush_flags.pop_front();
            words_checked++;
            if (flush_flag)
                flush_words_seen++;
            if (word !== want_word)
                report_mismatch($sformatf("packed_word %h, want %h", word, want_word));
            if (flush_flag !== want_flag)
                report_mismatch($sformatf("from_flush %0b, want %0b",
                                          flush_flag, want_flag));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------------
    logic aclk;
    logic aresetn;

    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;   // field_value[63:0], field_width[70:64], zero pad
    logic [0:0]              s_tuser;   // op
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;   // packed_word[63:0]
    logic [0:0]              m_tuser;   // from_flush

    // control between the stimulus and the receiver, updated at clock edges
    logic        no_idle;
    int unsigned hold_requests;
    int unsigned holds_granted;

    packer_scoreboard sb;
    int unsigned      items_sent;
    int unsigned      idle_cycles;

    variable_width_bit_packer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels with their pre-edge values. Check the
    // outgoing word before noting the incoming one so the order is fixed.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                sb.absorb_field(s_tuser[0], s_tdata[63:0], s_tdata[70:64]);
        end
    end

    // Watchdog: count cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("** variable_width_bit_packer_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drop m_tready at random with odds of 7 in 100, never while no_idle is
    // set, and hold it low for a long stretch whenever a hold-off is requested.
    // ------------------------------------------------------------------------
    initial begin
        m_tready      <= 1'b0;
        holds_granted  = 0;
        forever begin
            @(posedge aclk);
            if (holds_granted != hold_requests) begin
                holds_granted = hold_requests;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge aclk);
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one input word and hold it until the handshake. Keep s_tvalid high
    // across back-to-back words; drop it only for a random one-cycle gap.
    task send_item(input logic op, input logic [63:0] value, input logic [6:0] width);
        if (!no_idle && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, width, value};
        s_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
    endtask

    // Stop offering, wait for every owed word, then let the pipe settle.
    task drain_owed_words();
        s_tvalid <= 1'b0;
        while (sb.words_owed() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Pick a width: mostly legal sizes, some zero and some oversized.
    function logic [6:0] pick_width();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 7'd0;
        else if (r < 6)
            return 7'($urandom_range(65, 127));
        else if (r < 40)
            return 7'($urandom_range(1, 8));
        else if (r < 75)
            return 7'($urandom_range(9, 32));
        else if (r < 90)
            return 7'($urandom_range(33, 63));
        else
            return 7'd64;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned  counted;
        logic [63:0]  value;
        logic [6:0]   width;
        bit           flush_now;

        sb            = new();
        items_sent    = 0;
        idle_cycles   = 0;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_APPEND;
        no_idle      <= 1'b0;
        hold_requests <= 0;

        // hold reset low, then release
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // -------- directed corners --------
        send_item(OP_FLUSH,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64);   // empty flush after reset
        send_item(OP_APPEND, 64'h0000_0000_0000_0001, 7'd1);
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);   // overflow by one bit
        send_item(OP_APPEND, 64'h0000_0000_0000_0000, 7'd63);   // word exactly full
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);    // zero width on a full word
        send_item(OP_APPEND, 64'h0000_0000_0000_0001, 7'd1);    // full word leaves now
        send_item(OP_FLUSH,  64'h0,                   7'd1);    // one-bit partial word
        send_item(OP_FLUSH,  64'h0,                   7'd0);    // empty flush
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd32);
        send_item(OP_APPEND, 64'h0000_0000_1234_5678, 7'd32);   // exactly full again
        send_item(OP_FLUSH,  64'h0,                   7'd0);    // flush a full word
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd3);    // stray value bits
        send_item(OP_APPEND, 64'hDEAD_BEEF_0BAD_F00D, 7'd65);   // oversized width
        send_item(OP_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 7'd127);  // largest width code
        send_item(OP_APPEND, 64'h0,                   7'd64);
        send_item(OP_APPEND, 64'h5555_5555_5555_5555, 7'd60);
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_F3FF, 7'd10);   // overflow mid-field
        send_item(OP_APPEND, 64'h0,                   7'd0);
        send_item(OP_FLUSH,  64'h0,                   7'd0);
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_item(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_item(OP_FLUSH,  64'h0,                   7'd0);
        drain_owed_words();

        // -------- random fields --------
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            // run a stretch with no idling, then a long receiver hold-off while
            // the sender keeps offering, then a full drain
            if (counted == 300)
                no_idle <= 1'b1;
            else if (counted == 550)
                no_idle <= 1'b0;
            else if (counted == 800)
                hold_requests <= hold_requests + 1;
            else if (counted == 1200)
                drain_owed_words();

            flush_now = ($urandom_range(0, 99) < 6);
            value     = {$urandom, $urandom};
            width     = pick_width();
            // stray value bits: sometimes hand over a sparse value pattern
            if ($urandom_range(0, 9) == 0)
                value = value & {$urandom, $urandom};
            send_item(flush_now ? OP_FLUSH : OP_APPEND, value, width);
            if (flush_now || width != 7'd0)
                counted++;
        end

        // close the stream so the last partial word leaves as well
        send_item(OP_FLUSH, 64'h0, 7'd0);
        drain_owed_words();

        $display("fed %0d input words; checked %0d packed words, %0d of them from flush",
                 items_sent, sb.words_checked, sb.flush_words_seen);
        $display("covered zero, oversized and full widths, exact fills, empty flushes, stalls");
        if (sb.mismatches == 0 && sb.words_owed() == 0) begin
            $display("** variable_width_bit_packer_unit: PASSED **");
        end else begin
            $display("%0d mismatches, %0d words still owed",
                     sb.mismatches, sb.words_owed());
            $display("** variable_width_bit_packer_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vwbp_pkg.sv
hw/rtl/vwbp_front.sv
hw/rtl/vwbp_queue.sv
hw/rtl/vwbp_back.sv
hw/rtl/variable_width_bit_packer_unit.sv
tb/tb_variable_width_bit_packer_unit.sv
